@@ rtl/core/scld_pkg.sv @@
// Shared types and constants for the serial command line decoder.
// No dependencies; imported by every module of the block.
package scld_pkg;

  // Default line buffer size; a line holds one character less than this.
  localparam int LINE_BUFFER_SIZE_DEF = 10;

  // Width of the line length carried in a job; covers lines up to 63 characters.
  localparam int LEN_W = 6;

  // Characters of the line that take part in command matching.
  localparam int PREFIX_N = 6;

  // Entries in the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W = 14;
  localparam logic REG_INTEG_HI = 1'b0;
  localparam logic REG_INTEG_LO = 1'b1;
  localparam logic [THR_W-1:0] INTEG_HI_RESET = 14'd6666;
  localparam logic [THR_W-1:0] INTEG_LO_RESET = 14'd3333;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // Result kinds.
  localparam logic [1:0] KIND_TX        = 2'd0;
  localparam logic [1:0] KIND_COUNTED   = 2'd1;
  localparam logic [1:0] KIND_CONTINUOUS = 2'd2;

  // Command classes decided by the front end.
  localparam logic [2:0] CMD_ECHO  = 3'd0;
  localparam logic [2:0] CMD_MODE  = 3'd1;
  localparam logic [2:0] CMD_GAIN  = 3'd2;
  localparam logic [2:0] CMD_INTEG = 3'd3;
  localparam logic [2:0] CMD_COUNT = 3'd4;
  localparam logic [2:0] CMD_MEAS  = 3'd5;
  localparam logic [2:0] CMD_END   = 3'd6;

  // Fixed response texts.
  localparam logic TXT_BANG = 1'b0;
  localparam logic TXT_END  = 1'b1;

  // One accepted byte, classified.
  typedef struct packed {
    logic [7:0]       ch;   // byte to echo
    logic             bs;   // backspace erase sequence follows the echo
    logic             fin;  // line ends with this byte
    logic [2:0]       cmd;  // command class when fin
    logic             ok;   // argument well formed
    logic [13:0]      arg;  // gain digit or four-digit value
    logic [LEN_W-1:0] len;  // characters on the finished line
  } job_t;

  // Character of a response text at a position.
  function automatic logic [7:0] text_char(input logic sel, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_BANG;
    if (sel == TXT_END) begin
      case (idx)
        3'd0: ch = "E";
        3'd1: ch = "N";
        3'd2: ch = "D";
        3'd3: ch = CH_SPACE;
        default: ch = CH_BANG;
      endcase
    end
    return ch;
  endfunction

  // Position of the last character of a response text.
  function automatic logic [2:0] text_last(input logic sel);
    return (sel == TXT_END) ? 3'd4 : 3'd0;
  endfunction

endpackage

@@ rtl/core/serial_command_line_decoder.sv @@
// Top level of the serial command line decoder: threshold registers and wiring.
// Instantiates scld_front, scld_fifo and scld_back; uses scld_pkg.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_rx_byte
//   out_     output     out_valid / out_stall kind, tx_byte, reading_count, pins, last
//   cfg      input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// The front end classifies a byte in the cycle it is accepted; the back end first
// fetches a job, then sends its results, and reads each echoed line character from
// line memory before it sends it.
// Reset is synchronous; the line memory is not cleared and is read only where written.
// in_stall rises while the two-entry job queue is full or while a finished line is
// echoed from line memory; after a continuous request every byte is taken and dropped.
module serial_command_line_decoder import scld_pkg::*; #(
  parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_tx_byte,
  output logic [13:0]           out_reading_count,
  output logic                  out_mode_pin,
  output logic [1:0]            out_gain_pins,
  output logic [1:0]            out_integ_pins,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [THR_W-1:0] integ_hi_r, integ_lo_r;
  logic             cfg_wr;
  logic             q_push, q_full, q_pop, q_empty;
  job_t             q_wdata, q_rdata;
  logic [$clog2(LINE_BUFFER_SIZE-1)-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             echo_done;

  // Threshold registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {{(CFG_DATA_W - THR_W){1'b0}},
                   (paddr[2] == REG_INTEG_LO) ? integ_lo_r : integ_hi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_hi_r <= INTEG_HI_RESET;
      integ_lo_r <= INTEG_LO_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_INTEG_LO) begin
        integ_lo_r <= pwdata[THR_W-1:0];
      end else begin
        integ_hi_r <= pwdata[THR_W-1:0];
      end
    end
  end

  scld_front #(
    .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .echo_done (echo_done)
  );

  scld_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  scld_back #(
    .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .echo_done        (echo_done),
    .integ_hi         (integ_hi_r),
    .integ_lo         (integ_lo_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_reading_count(out_reading_count),
    .out_mode_pin     (out_mode_pin),
    .out_gain_pins    (out_gain_pins),
    .out_integ_pins   (out_integ_pins),
    .out_last         (out_last)
  );

endmodule

@@ rtl/core/scld_front.sv @@
// Front end: accepts received bytes, edits the line and classifies finished lines.
// Holds the line memory and its read port for the back end. Uses scld_pkg.
module scld_front import scld_pkg::*; #(
  parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       q_push,
  output job_t       q_wdata,
  input  logic       q_full,
  input  logic [$clog2(LINE_BUFFER_SIZE-1)-1:0] rd_addr,
  output logic [7:0] rd_data,
  input  logic       echo_done
);

  localparam int DEPTH = LINE_BUFFER_SIZE - 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic          halted_r, halted_nxt;
  logic          lock_r, lock_nxt;
  logic [7:0]    pre_r [PREFIX_N];
  logic [7:0]    pre_nxt [PREFIX_N];
  logic [7:0]    eff [PREFIX_N];
  logic [7:0]    line_mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          accept, store, fin, bs;
  logic          m_ssmode, m_sgain, m_si, m_scount, m_sm, m_send;
  logic          digits_ok, gain_ok;
  logic [13:0]   value;
  job_t          job;

  // Stall while the queue is full or the back end still reads the last line, unless halted
  assign in_stall = !halted_r && (q_full || lock_r);
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && !halted_r;
  assign q_wdata  = job;
  assign rd_data  = rd_data_r;

  // Edit the line with the incoming byte
  always_comb begin
    store   = 1'b0;
    fin     = 1'b0;
    bs      = 1'b0;
    cnt_nxt = cnt_r;
    cnt_eff = cnt_r;
    pre_nxt = pre_r;
    if (in_rx_byte == CH_BS && cnt_r != '0) begin
      bs      = 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end else if (in_rx_byte == CH_LF) begin
      cnt_nxt = cnt_r;
    end else if (in_rx_byte == CH_CR) begin
      fin = 1'b1;
    end else begin
      store   = 1'b1;
      cnt_eff = cnt_r + 1'b1;
      cnt_nxt = cnt_eff;
      for (int i = 0; i < PREFIX_N; i++) begin
        if (cnt_r == CW'(i)) pre_nxt[i] = in_rx_byte;
      end
      if (cnt_eff == CW'(DEPTH)) fin = 1'b1;
    end
    if (fin) cnt_nxt = '0;
  end

  // Mask characters beyond the line end
  always_comb begin
    for (int i = 0; i < PREFIX_N; i++) begin
      eff[i] = (CW'(i) < cnt_eff) ? pre_nxt[i] : CH_NUL;
    end
  end

  // Match command prefixes and arguments
  always_comb begin
    m_ssmode = eff[0] == "S" && eff[1] == "S" && eff[2] == "M" && eff[3] == "O" &&
               eff[4] == "D" && eff[5] == "E";
    m_sgain  = eff[0] == "S" && eff[1] == "G" && eff[2] == "A" && eff[3] == "I" &&
               eff[4] == "N";
    m_si     = eff[0] == "S" && eff[1] == "I";
    m_scount = eff[0] == "S" && eff[1] == "C" && eff[2] == "O" && eff[3] == "U" &&
               eff[4] == "N" && eff[5] == "T";
    m_sm     = eff[0] == "S" && eff[1] == "M";
    m_send   = eff[0] == "S" && eff[1] == "E" && eff[2] == "N" && eff[3] == "D";
    gain_ok  = eff[5] inside {["1":"3"]};
    digits_ok = (eff[2] inside {["0":"9"]}) && (eff[3] inside {["0":"9"]}) &&
                (eff[4] inside {["0":"9"]}) && (eff[5] inside {["0":"9"]});
    value = 14'(14'(eff[2][3:0]) * 14'd1000) + 14'(14'(eff[3][3:0]) * 14'd100) +
            14'(14'(eff[4][3:0]) * 14'd10) + 14'(eff[5][3:0]);
  end

  // Build the job for the back end
  always_comb begin
    job.ch  = in_rx_byte;
    job.bs  = bs;
    job.fin = fin;
    job.len = LEN_W'(cnt_eff);
    job.cmd = CMD_ECHO;
    job.ok  = 1'b0;
    job.arg = '0;
    if (m_ssmode) begin
      job.cmd = CMD_MODE;
      job.ok  = 1'b1;
    end else if (m_sgain) begin
      job.cmd = CMD_GAIN;
      job.ok  = gain_ok;
      job.arg = {12'd0, eff[5][1:0]};
    end else if (m_si) begin
      job.cmd = CMD_INTEG;
      job.ok  = digits_ok;
      job.arg = value;
    end else if (m_scount) begin
      job.cmd = CMD_COUNT;
    end else if (m_sm) begin
      if (digits_ok) begin
        job.cmd = CMD_MEAS;
        job.ok  = 1'b1;
        job.arg = value;
      end
    end else if (m_send) begin
      job.cmd = CMD_END;
    end
  end

  // Halt after a continuous request; lock the line while it is echoed
  always_comb begin
    halted_nxt = halted_r;
    lock_nxt   = lock_r;
    if (q_push && fin && job.cmd == CMD_COUNT) halted_nxt = 1'b1;
    if (q_push && fin && job.cmd == CMD_ECHO) begin
      lock_nxt = 1'b1;
    end else if (echo_done) begin
      lock_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      halted_r <= 1'b0;
      lock_r   <= 1'b0;
    end else begin
      halted_r <= halted_nxt;
      lock_r   <= lock_nxt;
      if (q_push) cnt_r <= cnt_nxt;
    end
  end

  // Matching copy of the first characters
  always_ff @(posedge clk) begin
    if (q_push) pre_r <= pre_nxt;
  end

  // Line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_push && store) line_mem[cnt_r[AW-1:0]] <= in_rx_byte;
    rd_data_r <= line_mem[rd_addr];
  end

endmodule

@@ rtl/core/scld_fifo.sv @@
// Short job queue between the front end and the back end.
// Uses job_t and QUEUE_DEPTH from scld_pkg.
module scld_fifo import scld_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] fill_r;

  assign full  = fill_r == NW'(QUEUE_DEPTH);
  assign empty = fill_r == '0;
  assign rdata = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ rtl/core/scld_back.sv @@
// Back end: carries out queued jobs, drives pin levels and sends results.
// Reads the front end's line memory for echoes. Uses scld_pkg.
module scld_back import scld_pkg::*; #(
  parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  job_t             q_rdata,
  output logic             q_pop,
  output logic [$clog2(LINE_BUFFER_SIZE-1)-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic             echo_done,
  input  logic [THR_W-1:0] integ_hi,
  input  logic [THR_W-1:0] integ_lo,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [13:0]      out_reading_count,
  output logic             out_mode_pin,
  output logic [1:0]       out_gain_pins,
  output logic [1:0]       out_integ_pins,
  output logic             out_last
);

  localparam int DEPTH = LINE_BUFFER_SIZE - 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHAR  = 4'd1;
  localparam logic [3:0] ST_SP    = 4'd2;
  localparam logic [3:0] ST_BSP   = 4'd3;
  localparam logic [3:0] ST_COUNT = 4'd4;
  localparam logic [3:0] ST_MEAS  = 4'd5;
  localparam logic [3:0] ST_TXT   = 4'd6;
  localparam logic [3:0] ST_ERD   = 4'd7;
  localparam logic [3:0] ST_EWR   = 4'd8;
  localparam logic [3:0] ST_CR    = 4'd9;
  localparam logic [3:0] ST_LF    = 4'd10;

  logic [3:0]    state_r, state_nxt;
  job_t          job_r, job_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          sel_r, sel_nxt;
  logic          mode_r, mode_nxt;
  logic [1:0]    gain_r, gain_nxt;
  logic [1:0]    integ_r, integ_nxt;
  logic [1:0]    integ_lvl;
  logic          can_emit, emit, e_last;
  logic [1:0]    e_kind;
  logic [7:0]    e_byte;
  logic [13:0]   e_count;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [7:0]    out_tx_byte_r;
  logic [13:0]   out_reading_count_r;
  logic          out_mode_pin_r;
  logic [1:0]    out_gain_pins_r;
  logic [1:0]    out_integ_pins_r;
  logic          out_last_r;

  assign can_emit = !out_valid_r || !out_stall;
  assign rd_addr  = idx_r[AW-1:0];

  // Integration level from the thresholds
  assign integ_lvl = (job_r.arg >= integ_hi) ? 2'd3 :
                     (job_r.arg >= integ_lo) ? 2'd2 : 2'd1;

  // Sequence one job into results
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    sel_nxt   = sel_r;
    mode_nxt  = mode_r;
    gain_nxt  = gain_r;
    integ_nxt = integ_r;
    q_pop     = 1'b0;
    echo_done = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_TX;
    e_byte    = CH_NUL;
    e_count   = '0;
    e_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_rdata;
          state_nxt = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_byte  = job_r.ch;
          e_last  = !job_r.bs && !job_r.fin;
          idx_nxt = '0;
          sel_nxt = TXT_BANG;
          if (job_r.bs) begin
            state_nxt = ST_SP;
          end else if (job_r.fin) begin
            case (job_r.cmd)
              CMD_MODE: begin
                mode_nxt  = 1'b1;
                state_nxt = ST_TXT;
              end
              CMD_GAIN: begin
                gain_nxt  = job_r.ok ? job_r.arg[1:0] : 2'd1;
                state_nxt = job_r.ok ? ST_TXT : ST_CR;
              end
              CMD_INTEG: begin
                integ_nxt = job_r.ok ? integ_lvl : 2'd1;
                state_nxt = job_r.ok ? ST_TXT : ST_CR;
              end
              CMD_COUNT: state_nxt = ST_COUNT;
              CMD_MEAS:  state_nxt = ST_MEAS;
              CMD_END: begin
                mode_nxt  = 1'b0;
                sel_nxt   = TXT_END;
                state_nxt = ST_TXT;
              end
              default: state_nxt = ST_ERD;
            endcase
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SP: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_byte    = CH_SPACE;
          state_nxt = ST_BSP;
        end
      end
      ST_BSP: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_byte    = CH_BS;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = KIND_CONTINUOUS;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MEAS: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = KIND_COUNTED;
          e_count   = job_r.arg;
          state_nxt = ST_TXT;
        end
      end
      ST_TXT: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = text_char(sel_r, idx_r[2:0]);
          if (idx_r[2:0] == text_last(sel_r)) begin
            state_nxt = ST_CR;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      // Read the next line character, or stop at the line end
      ST_ERD: begin
        if (idx_r == CW'(job_r.len)) begin
          echo_done = 1'b1;
          state_nxt = ST_CR;
        end else begin
          state_nxt = ST_EWR;
        end
      end
      // Send the character, or stop at a zero byte
      ST_EWR: begin
        if (rd_data == CH_NUL) begin
          echo_done = 1'b1;
          state_nxt = ST_CR;
        end else if (can_emit) begin
          emit      = 1'b1;
          e_byte    = rd_data;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_ERD;
        end
      end
      ST_CR: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_byte    = CH_CR;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_byte    = CH_LF;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and pin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      sel_r       <= TXT_BANG;
      mode_r      <= 1'b0;
      gain_r      <= 2'd0;
      integ_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sel_r   <= sel_nxt;
      mode_r  <= mode_nxt;
      gain_r  <= gain_nxt;
      integ_r <= integ_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the current job and the result payload
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_kind_r          <= e_kind;
      out_tx_byte_r       <= e_byte;
      out_reading_count_r <= e_count;
      out_mode_pin_r      <= mode_r;
      out_gain_pins_r     <= gain_r;
      out_integ_pins_r    <= integ_r;
      out_last_r          <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_tx_byte       = out_tx_byte_r;
  assign out_reading_count = out_reading_count_r;
  assign out_mode_pin      = out_mode_pin_r;
  assign out_gain_pins     = out_gain_pins_r;
  assign out_integ_pins    = out_integ_pins_r;
  assign out_last          = out_last_r;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for serial_command_line_decoder: directed line edits and
// commands, then random command traffic under random sender gaps and receiver stalls.
// Depends on scld_pkg and the serial_command_line_decoder RTL.
module testbench;
  import scld_pkg::*;

  localparam int LINE_CHARS = LINE_BUFFER_SIZE_DEF - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE_CYCLES = 40;

  // One decoder output transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [13:0] count;
    logic        mode;
    logic [1:0]  gain;
    logic [1:0]  integ;
    logic        last;
  } emit_t;

  typedef enum logic [1:0] {STALL_OFF, STALL_SPARSE, STALL_DENSE, STALL_BURSTY} stall_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_kind;
  logic [7:0]            out_tx_byte;
  logic [13:0]           out_reading_count;
  logic                  out_mode_pin;
  logic [1:0]            out_gain_pins;
  logic [1:0]            out_integ_pins;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  serial_command_line_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_reading_count (out_reading_count),
    .out_mode_pin      (out_mode_pin),
    .out_gain_pins     (out_gain_pins),
    .out_integ_pins    (out_integ_pins),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Decoder state as predicted by the testbench.
  logic [7:0]       line_mem [LINE_CHARS];
  int unsigned      line_len;
  logic             mode_lvl;
  logic [1:0]       gain_lvl;
  logic [1:0]       integ_lvl;
  logic             halted;
  logic [THR_W-1:0] thr_hi;
  logic [THR_W-1:0] thr_lo;

  emit_t        byte_emits[$];
  emit_t        awaited_out[$];
  logic [7:0]   line_text[$];
  int           n_errors;
  int           items_sent;
  int           burst_left;
  int           cycle_count;
  stall_style_t stall_style;
  int           stall_left;
  emit_t        seen_emit;
  emit_t        want_emit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_command_line_decoder regression: fail");
      $finish;
    end
  end

  // Receiver stall: pick a random style, and a new one when its random stretch runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_style)
      STALL_OFF:    out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_DENSE:  out_stall <= ($urandom_range(0, 3) != 0);
      default:      out_stall <= (cycle_count % 16) >= 11;
    endcase
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  function automatic void reset_decoder_state();
    thr_hi = INTEG_HI_RESET;
    thr_lo = INTEG_LO_RESET;
    foreach (line_mem[i]) line_mem[i] = CH_NUL;
    line_len = 0;
    mode_lvl = 1'b0;
    gain_lvl = '0;
    integ_lvl = '0;
    halted = 1'b0;
  endfunction

  // Append one output transaction carrying the current pin levels.
  function automatic void add_emit(logic [1:0] kind, logic [7:0] ch, logic [13:0] count);
    emit_t e;
    e.kind = kind;
    e.tx = ch;
    e.count = count;
    e.mode = mode_lvl;
    e.gain = gain_lvl;
    e.integ = integ_lvl;
    e.last = 1'b0;
    byte_emits.push_back(e);
  endfunction

  function automatic void add_text(string t);
    for (int i = 0; i < t.len(); i++) add_emit(KIND_TX, t[i], '0);
  endfunction

  // Character of the current line, zero past its end.
  function automatic logic [7:0] line_char(int unsigned i);
    return (i < line_len && i < LINE_CHARS) ? line_mem[i] : CH_NUL;
  endfunction

  function automatic bit line_starts(string p);
    for (int i = 0; i < p.len(); i++)
      if (line_char(i) != p[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Value of the four-digit argument, or -1 if any of it is not a digit.
  function automatic int arg_value();
    int v;
    logic [7:0] c;
    v = 0;
    for (int i = 2; i < 6; i++) begin
      c = line_char(i);
      if (c < "0" || c > "9") return -1;
      v = v * 10 + int'(c - "0");
    end
    return v;
  endfunction

  function automatic void echo_line();
    for (int unsigned i = 0; i < line_len && i < LINE_CHARS && line_mem[i] != CH_NUL; i++)
      add_emit(KIND_TX, line_mem[i], '0);
  endfunction

  // Match the finished line against the commands, first match wins.
  function automatic void close_line();
    int v;
    logic [7:0] g;
    if (line_starts("SSMODE")) begin
      mode_lvl = 1'b1;
      add_text("!");
    end else if (line_starts("SGAIN")) begin
      g = line_char(5);
      if (g >= "1" && g <= "3") begin
        gain_lvl = g[1:0];
        add_text("!");
      end else begin
        gain_lvl = 2'd1;
      end
    end else if (line_starts("SI")) begin
      v = arg_value();
      if (v >= 0) begin
        if (v >= int'(thr_hi)) integ_lvl = 2'd3;
        else if (v >= int'(thr_lo)) integ_lvl = 2'd2;
        else integ_lvl = 2'd1;
        add_text("!");
      end else begin
        integ_lvl = 2'd1;
      end
    end else if (line_starts("SCOUNT")) begin
      add_emit(KIND_CONTINUOUS, CH_NUL, '0);
      halted = 1'b1;
      return;
    end else if (line_starts("SM")) begin
      v = arg_value();
      if (v >= 0) begin
        add_emit(KIND_COUNTED, CH_NUL, 14'(v));
        add_text("!");
      end else begin
        echo_line();
      end
    end else if (line_starts("SEND")) begin
      mode_lvl = 1'b0;
      add_text("END !");
    end else begin
      echo_line();
    end
    add_emit(KIND_TX, CH_CR, '0);
    add_emit(KIND_TX, CH_LF, '0);
  endfunction

  // Queue every output transaction caused by one accepted byte.
  function automatic void decode_byte(logic [7:0] c);
    logic  done;
    emit_t tail;
    if (halted) return;
    byte_emits.delete();
    done = 1'b0;
    add_emit(KIND_TX, c, '0);
    if (c == CH_BS && line_len > 0) begin
      add_emit(KIND_TX, CH_SPACE, '0);
      add_emit(KIND_TX, CH_BS, '0);
      line_len--;
    end else if (c == CH_CR) begin
      done = 1'b1;
    end else if (c != CH_LF) begin
      // anything but a line feed is kept, including a backspace on an empty line
      if (line_len < LINE_CHARS) line_mem[line_len] = c;
      line_len++;
      if (line_len >= LINE_CHARS) done = 1'b1;
    end
    if (done) begin
      close_line();
      line_len = 0;
    end
    tail = byte_emits.pop_back();
    tail.last = 1'b1;
    byte_emits.push_back(tail);
    foreach (byte_emits[i]) awaited_out.push_back(byte_emits[i]);
  endfunction

  //--------------------------------------------------------------------------
  // Output check
  //--------------------------------------------------------------------------

  task automatic note_mismatch(string field, logic [13:0] want, logic [13:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_emit = '{out_kind, out_tx_byte, out_reading_count, out_mode_pin,
                    out_gain_pins, out_integ_pins, out_last};
      if (awaited_out.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0d byte %0h",
                 $time, out_kind, out_tx_byte);
        n_errors++;
      end else begin
        want_emit = awaited_out.pop_front();
        if (seen_emit.kind !== want_emit.kind)
          note_mismatch("kind", 14'(want_emit.kind), 14'(seen_emit.kind));
        if (seen_emit.tx !== want_emit.tx)
          note_mismatch("tx_byte", 14'(want_emit.tx), 14'(seen_emit.tx));
        if (seen_emit.count !== want_emit.count)
          note_mismatch("reading_count", want_emit.count, seen_emit.count);
        if (seen_emit.mode !== want_emit.mode)
          note_mismatch("mode_pin", 14'(want_emit.mode), 14'(seen_emit.mode));
        if (seen_emit.gain !== want_emit.gain)
          note_mismatch("gain_pins", 14'(want_emit.gain), 14'(seen_emit.gain));
        if (seen_emit.integ !== want_emit.integ)
          note_mismatch("integ_pins", 14'(want_emit.integ), 14'(seen_emit.integ));
        if (seen_emit.last !== want_emit.last)
          note_mismatch("last", 14'(want_emit.last), 14'(seen_emit.last));
      end
    end
  end

  //--------------------------------------------------------------------------
  // Drivers
  //--------------------------------------------------------------------------

  // Send one byte; hold it until taken, then maybe pause between bursts.
  task automatic send_byte(input logic [7:0] c);
    in_valid <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    decode_byte(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 10);
    end
  endtask

  task automatic send_command(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_CR);
  endtask

  // Drop valid and wait until every predicted transaction has come out.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic sel, input logic [CFG_DATA_W-1:0] value);
    paddr <= {sel, 2'b00};
    pwdata <= value;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_INTEG_HI) thr_hi = value[THR_W-1:0];
    else thr_lo = value[THR_W-1:0];
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] lo);
    drain_outputs();
    write_threshold(REG_INTEG_HI, hi);
    write_threshold(REG_INTEG_LO, lo);
  endtask

  //--------------------------------------------------------------------------
  // Random line builder
  //--------------------------------------------------------------------------

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
  endfunction

  // Four-digit argument, now and then cut short, biased toward the thresholds and the range ends.
  function automatic void append_arg();
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15 && thr_hi <= 9999) v = int'(thr_hi);
    else if (pick < 30 && thr_lo <= 9999) v = int'(thr_lo);
    else if (pick < 35) v = 0;
    else if (pick < 40) v = 9999;
    else v = $urandom_range(0, 9999);
    line_text.push_back(8'("0" + (v / 1000) % 10));
    line_text.push_back(8'("0" + (v / 100) % 10));
    if ($urandom_range(0, 19) == 0) return;  // short argument
    line_text.push_back(8'("0" + (v / 10) % 10));
    line_text.push_back(8'("0" + v % 10));
    // spoil one position now and then
    if ($urandom_range(0, 6) == 0)
      line_text[$urandom_range(2, 5)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_line();
    int pick;
    int pos;
    line_text.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      append_text("SSMODE");
    end else if (pick < 27) begin
      append_text("SGAIN");
      if ($urandom_range(0, 4) == 0) line_text.push_back(8'($urandom_range(0, 255)));
      else line_text.push_back(8'("0" + $urandom_range(0, 4)));
    end else if (pick < 47) begin
      append_text("SI");
      append_arg();
    end else if (pick < 67) begin
      append_text("SM");
      append_arg();
    end else if (pick < 75) begin
      append_text("SEND");
    end else if (pick < 88) begin
      repeat ($urandom_range(0, 10)) line_text.push_back(8'($urandom_range(32, 126)));
    end else begin
      repeat ($urandom_range(1, 12)) line_text.push_back(8'($urandom_range(0, 255)));
    end
    // typo then erase
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, line_text.size());
      line_text.insert(pos, CH_BS);
      line_text.insert(pos, 8'($urandom_range(33, 126)));
    end
    if ($urandom_range(0, 11) == 0) line_text.insert($urandom_range(0, line_text.size()), CH_LF);
    if ($urandom_range(0, 24) == 0) line_text.insert($urandom_range(0, line_text.size()), CH_NUL);
    if ($urandom_range(0, 7) != 0) line_text.push_back(CH_CR);
    foreach (line_text[i]) send_byte(line_text[i]);
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Backspace on empty and non-empty lines, line feed, zero and all-ones bytes, full line.
  task automatic test_line_editing();
    send_byte(CH_BS);
    send_byte("A");
    send_byte(CH_BS);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_byte("Z");
    send_byte(CH_CR);
    append_text("SM12x4567");
    foreach (line_text[i]) send_byte(line_text[i]);
    line_text.delete();
  endtask

  task automatic test_mode_commands();
    send_command("SSMODE");
    send_command("SEND");
  endtask

  task automatic test_gain_commands();
    send_command("SGAIN3");
    send_command("SGAINx");
  endtask

  // Integration levels at the reset thresholds, then at extreme settings.
  task automatic test_integration_commands();
    send_command("SI6666");
    send_command("SI3332");
    send_command("SI12");
    set_thresholds(32'd0, 32'd0);
    send_command("SI0000");
    set_thresholds(32'hFFFF_3FFF, 32'd16383);
    send_command("SI9999");
    set_thresholds(32'd100, 32'd9000);
    send_command("SI5000");
    send_command("SI0050");
  endtask

  task automatic test_measure_requests();
    send_command("SM0000");
    send_command("SM9999");
  endtask

  // Random traffic in phases, each under its own threshold setting.
  task automatic test_random_traffic();
    int phase_end;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       set_thresholds(32'd9999, 32'd0);
        2:       set_thresholds(32'd0, 32'd9999);
        3:       set_thresholds({16'($urandom_range(0, 65535)), 16'd16383}, 32'd16383);
        default: set_thresholds($urandom_range(0, 9999), $urandom_range(0, 9999));
      endcase
      phase_end = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < phase_end) send_random_line();
    end
  endtask

  // Continuous request halts the block; later bytes are taken and dropped.
  task automatic test_continuous_request();
    drain_outputs();
    send_command("SCOUNT");
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    send_command("SEND");
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    items_sent = 0;
    burst_left = 0;
    reset_decoder_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_line_editing();
    test_mode_commands();
    test_gain_commands();
    test_integration_commands();
    test_measure_requests();
    test_random_traffic();
    test_continuous_request();

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("serial_command_line_decoder regression: pass");
    end else begin
      $display("serial_command_line_decoder regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/scld_pkg.sv
rtl/core/scld_front.sv
rtl/core/scld_fifo.sv
rtl/core/scld_back.sv
rtl/core/serial_command_line_decoder.sv
dv/testbench.sv
